// ----- hw/rtl/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational sum accumulator package
// Shared widths, payload types and sequencer states.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int MAG_WIDTH   = 64;
   localparam int CNT_WIDTH   = 7;

   typedef struct packed {
      logic        restart;
      logic [31:0] addend_num;
      logic [31:0] addend_den;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] total_num;
      logic [30:0] total_den;
      logic        overflow;
      logic        bad_input;
   } rsp_payload_type;

   // Divider control and status.
   typedef struct packed {
      logic                 start;
      logic [MAG_WIDTH-1:0] dividend;
      logic [MAG_WIDTH-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [MAG_WIDTH-1:0] quotient;
      logic [MAG_WIDTH-1:0] remainder;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_G1_DIV,
      ST_G1_WAIT,
      ST_RN_DIV,
      ST_RN_WAIT,
      ST_RD_DIV,
      ST_RD_WAIT,
      ST_MUL,
      ST_ADD,
      ST_G2_DIV,
      ST_G2_WAIT,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

// ----- hw/rtl/rsa_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload with valid and ready between a source and a sink.
// ----------------------------------------------------------------------------
interface rsa_if #(type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/rational_sum_accumulator.sv -----
// ----------------------------------------------------------------------------
// Rational sum accumulator
// Running sum of signed fractions kept in lowest terms.
// ----------------------------------------------------------------------------
// One item at a time. Each item runs Euclidean gcd steps on a shared
// bit-serial divider. A division is started in a DIV state and awaited in
// the matching WAIT state until the done pulse. An item runs the gcd steps
// of the addend, two divisions to reduce the addend, the gcd steps of the
// sum and two more divisions to reduce the sum. When the sum is zero, the
// sum gcd and its reduction are skipped. Zero denominators and zero addends
// return their result in the cycle after the transfer.
module rational_sum_accumulator
   import rsa_pkg::*;
(
   input logic clock,
   input logic reset,
   rsa_if.sink   req,
   rsa_if.source rsp
);

   localparam logic [MAG_WIDTH-1:0] LIMIT = MAG_WIDTH'((64'd1 << (VALUE_WIDTH - 1)) - 1);

   state_type state_ff, state_in;

   logic [31:0]          sn_ff, sn_in;        // sum numerator, two's complement
   logic [30:0]          sd_ff, sd_in;
   logic [MAG_WIDTH-1:0] an_ff, an_in, ad_ff, ad_in;
   logic                 aneg_ff, aneg_in;
   logic [MAG_WIDTH-1:0] ga_ff, ga_in, gb_ff, gb_in;  // gcd pair
   logic [MAG_WIDTH-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic                 rneg_ff, rneg_in;
   logic [MAG_WIDTH-1:0] p_ff, p_in, q_ff, q_in;
   logic [1:0]           mstep_ff, mstep_in;
   logic                 sum_pass_ff, sum_pass_in;  // reducing the new sum
   rsp_payload_type      out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   div_cmd_type  dcmd;
   div_stat_type dstat;

   logic        req_fire;
   logic        in_an_neg, in_ad_neg;
   logic [31:0] in_an, in_ad;
   logic        s_neg;
   logic [31:0] s_mag;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   rsa_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .stat  (dstat)
   );

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = out_ff;

   // Input magnitudes and signs.
   assign in_an_neg = req.payload.addend_num[31];
   assign in_ad_neg = req.payload.addend_den[31];
   assign in_an = in_an_neg ? (32'd0 - req.payload.addend_num) : req.payload.addend_num;
   assign in_ad = in_ad_neg ? (32'd0 - req.payload.addend_den) : req.payload.addend_den;
   assign s_neg = sn_ff[31];
   assign s_mag = s_neg ? (32'd0 - sn_ff) : sn_ff;

   // Shared 32x32 multiplier, one product per cycle.
   always_comb begin
      case (mstep_ff)
         2'd0:    begin mul_a = s_mag;        mul_b = ad_ff[31:0]; end
         2'd1:    begin mul_a = {1'b0, sd_ff}; mul_b = an_ff[31:0]; end
         default: begin mul_a = {1'b0, sd_ff}; mul_b = ad_ff[31:0]; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && in_ad != 32'd0 && in_an != 32'd0) state_in = ST_G1_DIV;
         end
         ST_G1_DIV:  state_in = (gb_ff == '0) ? ST_RN_DIV : ST_G1_WAIT;
         ST_G1_WAIT: if (dstat.done) state_in = ST_G1_DIV;
         ST_RN_DIV:  state_in = ST_RN_WAIT;
         ST_RN_WAIT: if (dstat.done) state_in = ST_RD_DIV;
         ST_RD_DIV:  state_in = ST_RD_WAIT;
         ST_RD_WAIT: begin
            if (dstat.done) begin
               state_in = (sum_pass_ff || s_mag == 32'd0) ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL:     if (mstep_ff == 2'd2) state_in = ST_ADD;
         ST_ADD:     state_in = ST_G2_DIV;
         ST_G2_DIV: begin
            if (rn_ff == '0) state_in = ST_FIN;
            else if (gb_ff == '0) state_in = ST_RN_DIV;
            else state_in = ST_G2_WAIT;
         end
         ST_G2_WAIT: if (dstat.done) state_in = ST_G2_DIV;
         ST_FIN:     state_in = ST_OUT;
         ST_OUT:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      sn_in = sn_ff; sd_in = sd_ff;
      an_in = an_ff; ad_in = ad_ff; aneg_in = aneg_ff;
      ga_in = ga_ff; gb_in = gb_ff;
      rn_in = rn_ff; rd_in = rd_ff; rneg_in = rneg_ff;
      p_in = p_ff; q_in = q_ff; mstep_in = mstep_ff;
      sum_pass_in = sum_pass_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff;
      dcmd.start = 1'b0;
      dcmd.dividend = ga_ff;
      dcmd.divisor = gb_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               an_in   = MAG_WIDTH'(in_an);
               ad_in   = MAG_WIDTH'(in_ad);
               aneg_in = in_an_neg ^ in_ad_neg;
               ga_in   = MAG_WIDTH'(in_an);
               gb_in   = MAG_WIDTH'(in_ad);
               rn_in   = MAG_WIDTH'(in_an);
               rd_in   = MAG_WIDTH'(in_ad);
               mstep_in = 2'd0;
               sum_pass_in = 1'b0;
               if (in_ad == 32'd0) begin
                  out_in = '{sn_ff, sd_ff, 1'b0, 1'b1};
                  rsp_valid_in = 1'b1;
               end else begin
                  if (req.payload.restart) begin
                     sn_in = '0;
                     sd_in = 31'd1;
                  end
                  if (in_an == 32'd0) begin
                     out_in = req.payload.restart ? '{32'd0, 31'd1, 1'b0, 1'b0}
                                                  : '{sn_ff, sd_ff, 1'b0, 1'b0};
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_G1_DIV, ST_G2_DIV: begin
            // Gcd step: start a % b, or finish with a as the gcd.
            if (gb_ff != '0 && !(state_ff == ST_G2_DIV && rn_ff == '0)) begin
               dcmd.start = 1'b1;
            end else begin
               gb_in = ga_ff;   // gcd now held as the divisor
            end
         end
         ST_G1_WAIT, ST_G2_WAIT: begin
            if (dstat.done) begin
               ga_in = gb_ff;
               gb_in = dstat.remainder;
            end
         end
         ST_RN_DIV: begin
            dcmd.start = 1'b1;
            dcmd.dividend = rn_ff;
         end
         ST_RN_WAIT: if (dstat.done) rn_in = dstat.quotient;
         ST_RD_DIV: begin
            dcmd.start = 1'b1;
            dcmd.dividend = rd_ff;
         end
         ST_RD_WAIT: begin
            if (dstat.done) begin
               rd_in = dstat.quotient;
               // The reduced addend feeds the multiplier; the reduced sum keeps its sign.
               if (!sum_pass_ff) begin
                  an_in = rn_ff;
                  ad_in = dstat.quotient;
                  rneg_in = aneg_ff;
               end
            end
         end
         ST_MUL: begin
            case (mstep_ff)
               2'd0:    p_in  = mul_p;
               2'd1:    q_in  = mul_p;
               default: rd_in = mul_p;
            endcase
            mstep_in = mstep_ff + 2'd1;
         end
         ST_ADD: begin
            if (s_neg == aneg_ff) begin
               rn_in = p_ff + q_ff; rneg_in = s_neg;
            end else if (p_ff >= q_ff) begin
               rn_in = p_ff - q_ff; rneg_in = s_neg;
            end else begin
               rn_in = q_ff - p_ff; rneg_in = aneg_ff;
            end
            ga_in = rn_in;
            gb_in = rd_ff;
            sum_pass_in = 1'b1;
         end
         ST_FIN: begin
            if (rn_ff == '0) begin
               rd_in = 64'd1;
               rneg_in = 1'b0;
            end
         end
         ST_OUT: begin
            if (rn_ff > LIMIT || rd_ff > LIMIT) begin
               out_in = '{sn_ff, sd_ff, 1'b1, 1'b0};
            end else begin
               sn_in = rneg_ff ? (32'd0 - rn_ff[31:0]) : rn_ff[31:0];
               sd_in = rd_ff[30:0];
               out_in = '{sn_in, sd_in, 1'b0, 1'b0};
            end
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sn_ff        <= '0;
         sd_ff        <= 31'd1;
         mstep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sn_ff        <= sn_in;
         sd_ff        <= sd_in;
         mstep_ff     <= mstep_in;
      end
      an_ff <= an_in; ad_ff <= ad_in; aneg_ff <= aneg_in;
      ga_ff <= ga_in; gb_ff <= gb_in;
      rn_ff <= rn_in; rd_ff <= rd_in; rneg_ff <= rneg_in;
      p_ff <= p_in; q_ff <= q_in;
      sum_pass_ff <= sum_pass_in;
      out_ff <= out_in;
   end

   // The stored denominator is never zero.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset) sd_ff != 31'd0)
      else $error("sum denominator is zero");
   // Both flags never rise together.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_ff.overflow && out_ff.bad_input))
      else $error("both flags set");
   // No item is taken while a result waits.
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready)
      else $error("ready while result pending");

endmodule

// ----- hw/rtl/rsa_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsa_div
   import rsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   logic [MAG_WIDTH-1:0] quo_ff, quo_in;
   logic [MAG_WIDTH-1:0] rem_ff, rem_in;
   logic [MAG_WIDTH-1:0] dvs_ff, dvs_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MAG_WIDTH:0]   trial;
   logic [MAG_WIDTH:0]   diff;

   // One shift-subtract step per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[MAG_WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[MAG_WIDTH]) begin
            rem_in = diff[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(MAG_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

// ----- dv/tb_rational_sum_accumulator.sv -----
// ----------------------------------------------------------------------------
// Rational sum accumulator testbench
// Drives signed fractions through the request channel and checks each
// running sum, including its flags, against a predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_rational_sum_accumulator;
   import rsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 400000;

   logic clock;
   logic reset;

   rsa_if #(.payload_type(req_payload_type)) req_ch ();
   rsa_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   rational_sum_accumulator u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Clock with a 4 ns period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   req_payload_type fraction_queue[$];
   rsp_payload_type expected_sums[$];
   logic [31:0]     acc_num;
   logic [30:0]     acc_den;
   int              error_count = 0;
   int              transfers_in = 0;
   int              transfers_out = 0;
   int              flagged_overflow = 0;
   int              flagged_bad = 0;
   int              idle_cycles = 0;
   bit              stimulus_done = 0;
   bit              hold_sender = 0;
   int              burst_left = 0;
   int              gap_left = 0;

   function automatic logic [63:0] euclid_gcd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Update the running sum for one fraction and return the expected response.
   function automatic rsp_payload_type add_fraction(input req_payload_type f);
      rsp_payload_type res;
      logic [63:0] limit, an, ad, sn, sd, rn, rd, p, q, g;
      logic an_neg, ad_neg, a_neg, s_neg, r_neg, ovf, bad;
      limit = (64'd1 << (VALUE_WIDTH - 1)) - 1;
      an_neg = f.addend_num[31];
      ad_neg = f.addend_den[31];
      an = an_neg ? 64'h1_0000_0000 - f.addend_num : {32'd0, f.addend_num};
      ad = ad_neg ? 64'h1_0000_0000 - f.addend_den : {32'd0, f.addend_den};
      ovf = 0;
      bad = 0;
      if (ad == 0) begin
         bad = 1;
      end else begin
         if (f.restart) begin
            acc_num = '0;
            acc_den = 31'd1;
         end
         if (an != 0) begin
            g = euclid_gcd(an, ad);
            a_neg = an_neg != ad_neg;
            an = an / g;
            ad = ad / g;
            s_neg = acc_num[31];
            sn = s_neg ? 64'h1_0000_0000 - acc_num : {32'd0, acc_num};
            sd = {33'd0, acc_den};
            if (sn == 0) begin
               rn = an;
               rd = ad;
               r_neg = a_neg;
            end else begin
               p = sn * ad;
               q = sd * an;
               rd = sd * ad;
               if (s_neg == a_neg) begin
                  rn = p + q;
                  r_neg = s_neg;
               end else if (p >= q) begin
                  rn = p - q;
                  r_neg = s_neg;
               end else begin
                  rn = q - p;
                  r_neg = a_neg;
               end
               if (rn == 0) begin
                  rd = 1;
                  r_neg = 0;
               end else begin
                  g = euclid_gcd(rn, rd);
                  rn = rn / g;
                  rd = rd / g;
               end
            end
            if (rn > limit || rd > limit) begin
               ovf = 1;
            end else begin
               acc_num = (r_neg && rn != 0) ? 32'd0 - rn[31:0] : rn[31:0];
               acc_den = rd[30:0];
            end
         end
      end
      res.total_num = acc_num;
      res.total_den = acc_den;
      res.overflow = ovf;
      res.bad_input = bad;
      return res;
   endfunction

   function automatic logic [31:0] pick_value(input bit den);
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0001;
         3: return den ? 32'd0 : 32'd0;
         4, 5: return $urandom();
         default: return $urandom_range(0, 1) ? $urandom_range(1, 60)
                                              : 32'd0 - $urandom_range(1, 60);
      endcase
   endfunction

   function automatic req_payload_type make_fraction(input logic rs, input logic [31:0] n,
                                                     input logic [31:0] d);
      req_payload_type f;
      f.restart = rs;
      f.addend_num = n;
      f.addend_den = d;
      return f;
   endfunction

   // Append one fraction to the stimulus queue.
   function automatic void queue_fraction(input logic rs, input logic [31:0] n,
                                          input logic [31:0] d);
      fraction_queue = {fraction_queue, make_fraction(rs, n, d)};
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_sums = {expected_sums, add_fraction(req_ch.payload)};
            transfers_in <= transfers_in + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (fraction_queue.size() > 0 && !hold_sender) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= fraction_queue.pop_front();
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls on its own pattern and checks every transfer.
   always @(posedge clock) begin
      rsp_payload_type exp_sum;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (transfers_out % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
         if (rsp_ch.valid && rsp_ch.ready) begin
            transfers_out <= transfers_out + 1;
            if (expected_sums.size() == 0) begin
               $error("unexpected response transfer");
               error_count = error_count + 1;
            end else begin
               exp_sum = expected_sums.pop_front();
               if (rsp_ch.payload.overflow) flagged_overflow <= flagged_overflow + 1;
               if (rsp_ch.payload.bad_input) flagged_bad <= flagged_bad + 1;
               if (rsp_ch.payload.total_num !== exp_sum.total_num) begin
                  $error("total_num expected %0d actual %0d", $signed(exp_sum.total_num),
                         $signed(rsp_ch.payload.total_num));
                  error_count = error_count + 1;
               end
               if (rsp_ch.payload.total_den !== exp_sum.total_den) begin
                  $error("total_den expected %0d actual %0d", exp_sum.total_den,
                         rsp_ch.payload.total_den);
                  error_count = error_count + 1;
               end
               if (rsp_ch.payload.overflow !== exp_sum.overflow) begin
                  $error("overflow expected %0b actual %0b", exp_sum.overflow,
                         rsp_ch.payload.overflow);
                  error_count = error_count + 1;
               end
               if (rsp_ch.payload.bad_input !== exp_sum.bad_input) begin
                  $error("bad_input expected %0b actual %0b", exp_sum.bad_input,
                         rsp_ch.payload.bad_input);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (!stimulus_done || expected_sums.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses pending", expected_sums.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] n;
      logic [31:0] d;
      acc_num = '0;
      acc_den = 31'd1;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      // Directed: extremes, zero denominator, zero addend, overflow, cancellation.
      queue_fraction(0, 32'd1, 32'd2);
      queue_fraction(0, 32'd1, 32'd3);
      queue_fraction(0, 32'd0 - 32'd5, 32'd6);
      queue_fraction(1, 32'd7, 32'd0);
      queue_fraction(0, 32'd0, 32'd9);
      queue_fraction(1, 32'd4, 32'd0 - 32'd8);
      queue_fraction(0, 32'd1, 32'd2);
      queue_fraction(1, 32'h8000_0000, 32'd1);
      queue_fraction(1, 32'd1, 32'h8000_0000);
      queue_fraction(1, 32'h8000_0000, 32'd2);
      queue_fraction(1, 32'h8000_0000, 32'h8000_0000);
      queue_fraction(1, 32'h7FFF_FFFF, 32'd1);
      queue_fraction(0, 32'd1, 32'd1);
      queue_fraction(1, 32'd1, 32'h7FFF_FFFF);
      queue_fraction(0, 32'd1, 32'h7FFF_FFFE);
      queue_fraction(1, 32'h8000_0001, 32'h7FFF_FFFF);
      queue_fraction(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_fraction(1, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_fraction(0, 32'hFFFF_FFFF, 32'h8000_0001);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (fraction_queue.size() == 0);
      // Hold off until the block has drained every pending response.
      hold_sender = 1;
      wait (expected_sums.size() == 0 && !req_ch.valid);
      hold_sender = 0;
      // Random part: small values most often, some extremes, zeros and full-range values.
      for (int i = 0; i < 1400; i++) begin
         n = pick_value(0);
         d = pick_value(1);
         if (d == 0 && $urandom_range(0, 3) != 0) d = 32'd1;
         queue_fraction($urandom_range(0, 15) == 0, n, d);
         if (i == 700) begin
            wait (fraction_queue.size() == 0);
            hold_sender = 1;
            wait (expected_sums.size() == 0 && !req_ch.valid);
            hold_sender = 0;
         end
      end
      wait (fraction_queue.size() == 0 && !req_ch.valid);
      stimulus_done = 1;
      wait (expected_sums.size() == 0);
      repeat (100) @(posedge clock);
      $display("covered %0d fractions, %0d sums returned, %0d overflow and %0d bad input flags",
               transfers_in, transfers_out, flagged_overflow, flagged_bad);
      if (error_count == 0 && expected_sums.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
